### design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue: operation and status
// codes, the entry format and the per-cycle command broadcast to the cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int ID_W   = 16;
  localparam int PRIO_W = 16;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_POP     = 2'd1,
    OP_UPGRADE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_DOWNGRADE = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    PH_IDLE   = 1'b0,
    PH_UPDATE = 1'b1
  } phase_t;

  // What every cell does on the update edge.
  //   MODE_INSERT    : make room at the insert point, slide the tail right
  //   MODE_POP       : everything slides left
  //   MODE_UPG_FRONT : front entry rewritten in place
  //   MODE_UPG_LEFT  : new spot at or before the match, fill the hole from the left
  //   MODE_UPG_RIGHT : same priority, entry moves behind its equals, fill from the right
  typedef enum logic [2:0] {
    MODE_HOLD      = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_POP       = 3'd2,
    MODE_UPG_FRONT = 3'd3,
    MODE_UPG_LEFT  = 3'd4,
    MODE_UPG_RIGHT = 3'd5
  } mode_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    mode_t  mode;
    entry_t ent;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### design/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. Registers its entry, and on the compare edge
// whether it is occupied with priority <= the new one and whether its id
// matches. Passes the first-match flag and matched priority down the row and
// picks its next entry from its neighbors on the update edge.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic              clk,
  input  wire logic              cmp_en,
  input  wire logic [ID_W-1:0]   cmp_id,
  input  wire logic [PRIO_W-1:0] cmp_prio,
  input  wire logic [CNT_W-1:0]  count,
  input  wire cell_ctrl_t        ctrl,
  input  wire entry_t            left_ent,
  input  wire logic              left_le,
  input  wire entry_t            right_ent,
  input  wire logic              right_le,
  input  wire logic              seen_in,
  input  wire logic [PRIO_W-1:0] fprio_in,
  output entry_t                 ent,
  output entry_t                 ent_next,
  output logic                   le,
  output logic                   seen_out,
  output logic [PRIO_W-1:0]      fprio_out
);

  logic match;
  logic occupied;

  assign occupied = (CNT_W'(IDX) < count);

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      le    <= occupied && (ent.prio <= cmp_prio);
      match <= occupied && (ent.id == cmp_id);
    end
    ent <= ent_next;
  end

  assign seen_out  = seen_in | match;
  assign fprio_out = seen_in ? fprio_in : ent.prio;

  always_comb begin
    ent_next = ent;
    case (ctrl.mode)
      MODE_INSERT: begin
        if (!le) ent_next = left_le ? ctrl.ent : left_ent;
      end
      MODE_POP: begin
        ent_next = right_ent;
      end
      MODE_UPG_FRONT: begin
        if (match && !seen_in) ent_next = ctrl.ent;
      end
      MODE_UPG_LEFT: begin
        // only cells up to and including the match move
        if (!le && !seen_in) ent_next = left_le ? ctrl.ent : left_ent;
      end
      MODE_UPG_RIGHT: begin
        if (seen_in || match) begin
          if (right_le)  ent_next = right_ent;
          else if (le)   ent_next = ctrl.ent;
        end
      end
      default: ent_next = ent;
    endcase
  end

endmodule

`default_nettype wire

### design/stable_priority_queue_unit.sv
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Sorted priority queue built as a row of entry cells.
// ----------------------------------------------------------------------------
// Holds up to CAPACITY entries sorted by ascending priority, equal priorities
// in arrival order, one entry per cell. Each operation beat runs as a compare
// step and an update step: on the accept edge every cell compares itself
// against the beat in parallel, and on the commit edge that follows the cells
// shift or load from their neighbors and the result is written to the output
// register. in_stall is high in the update phase, which holds while an earlier
// result is still stalled in the output register, so a new beat is taken only
// after the current one commits. Each beat yields exactly one result beat. No
// clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        op,
  input  wire logic [ID_W-1:0]   entry_id,
  input  wire logic [PRIO_W-1:0] entry_priority,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ID_W-1:0]        removed_id,
  output logic [PRIO_W-1:0]      removed_priority,
  output logic [ID_W-1:0]        front_id,
  output logic [PRIO_W-1:0]      front_priority,
  output logic [4:0]             entry_count,
  output logic [2:0]             status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  phase_t phase, phase_next;
  logic   in_accept;
  logic   commit;

  op_t               op_q;
  logic [ID_W-1:0]   id_q;
  logic [PRIO_W-1:0] prio_q;
  logic [CNT_W-1:0]  count, count_next;

  cell_ctrl_t ctrl;
  status_t    st_next;

  entry_t            cur   [CAPACITY];
  entry_t            nxt   [CAPACITY];
  logic              le    [CAPACITY];
  logic              seen  [CAPACITY];
  logic [PRIO_W-1:0] fprio [CAPACITY];

  assign in_accept = in_valid && !in_stall;
  assign commit    = (phase == PH_UPDATE) && (!out_valid || !out_stall);

  // ---- cell row ----
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t            l_ent, r_ent;
    logic              l_le, r_le, s_in;
    logic [PRIO_W-1:0] f_in;

    if (g == 0) begin : g_head
      assign l_ent = '0;
      assign l_le  = 1'b1;
      assign s_in  = 1'b0;
      assign f_in  = '0;
    end else begin : g_mid
      assign l_ent = cur[g-1];
      assign l_le  = le[g-1];
      assign s_in  = seen[g-1];
      assign f_in  = fprio[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign r_ent = '0;
      assign r_le  = 1'b0;
    end else begin : g_body
      assign r_ent = cur[g+1];
      assign r_le  = le[g+1];
    end

    spq_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (in_accept),
      .cmp_id    (entry_id),
      .cmp_prio  (entry_priority),
      .count     (count),
      .ctrl      (ctrl),
      .left_ent  (l_ent),
      .left_le   (l_le),
      .right_ent (r_ent),
      .right_le  (r_le),
      .seen_in   (s_in),
      .fprio_in  (f_in),
      .ent       (cur[g]),
      .ent_next  (nxt[g]),
      .le        (le[g]),
      .seen_out  (seen[g]),
      .fprio_out (fprio[g])
    );
  end

  // ---- phase control ----
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:   if (in_accept) phase_next = PH_UPDATE;
      PH_UPDATE: if (commit)    phase_next = PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    case (phase)
      PH_IDLE: in_stall = 1'b0;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      count     <= count_next;
      out_valid <= commit || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_q   <= op_t'(op);
      id_q   <= entry_id;
      prio_q <= entry_priority;
    end
  end

  // ---- update decision ----
  always_comb begin
    ctrl.mode  = MODE_HOLD;
    ctrl.ent   = '{id: id_q, prio: prio_q};
    st_next    = ST_OK;
    count_next = count;
    case (op_q)
      OP_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          st_next = ST_FULL;
        end else begin
          ctrl.mode  = MODE_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_POP: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else begin
          ctrl.mode  = MODE_POP;
          count_next = count - 1'b1;
        end
      end
      OP_UPGRADE: begin
        if (count == '0) begin
          st_next = ST_EMPTY;
        end else if (!seen[CAPACITY-1]) begin
          st_next = ST_NOT_FOUND;
        end else if (prio_q > fprio[CAPACITY-1]) begin
          st_next = ST_DOWNGRADE;
        end else if (seen[0]) begin
          ctrl.mode = MODE_UPG_FRONT;
        end else if (prio_q == fprio[CAPACITY-1]) begin
          ctrl.mode = MODE_UPG_RIGHT;
        end else begin
          ctrl.mode = MODE_UPG_LEFT;
        end
      end
      OP_CLEAR: begin
        if (count == '0) st_next = ST_EMPTY;
        count_next = '0;
      end
      default: st_next = ST_OK;
    endcase
    if (!commit) begin
      ctrl.mode  = MODE_HOLD;
      count_next = count;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (commit) begin
      if (ctrl.mode == MODE_POP) begin
        removed_id       <= cur[0].id;
        removed_priority <= cur[0].prio;
      end else begin
        removed_id       <= '0;
        removed_priority <= '0;
      end
      if (count_next != '0) begin
        front_id       <= nxt[0].id;
        front_priority <= nxt[0].prio;
      end else begin
        front_id       <= '0;
        front_priority <= '0;
      end
      entry_count <= 5'(count_next);
      status      <= st_next;
    end
  end

endmodule

`default_nettype wire

### design/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker
  import spq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [ID_W-1:0]   removed_id,
  input wire logic [ID_W-1:0]   front_id,
  input wire logic [PRIO_W-1:0] front_priority,
  input wire logic [4:0]        entry_count,
  input wire logic [2:0]        status
);

  // one beat in flight: the cycle after an accept is always a stall
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("beat accepted on back-to-back cycles");

  a_empty_front: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_count == 5'd0 && CAPACITY < 32) |->
      (front_id == '0 && front_priority == '0))
    else $error("front reported while queue empty");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (entry_count == 5'd0))
    else $error("empty status with entries held");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (entry_count == 5'(CAPACITY)))
    else $error("full status below capacity");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(removed_id) && $stable(status)))
    else $error("stalled result beat changed");

endmodule

bind stable_priority_queue_unit spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .removed_id     (removed_id),
  .front_id       (front_id),
  .front_priority (front_priority),
  .entry_count    (entry_count),
  .status         (status)
);

`default_nettype wire
